FILE: rtl/tpim_pkg.sv
// ----------------------------------------------------------------------------
// tpim_pkg
// Shared widths, codes and the lane record for the triangular pair index map.
// ----------------------------------------------------------------------------
package tpim_pkg;

    localparam int ITEMS_W = 17;   // item count N, row/column results
    localparam int ROW_W   = 16;   // row searched by the cell chain
    localparam int INDEX_W = 32;   // pair index and pair total
    localparam int SUM_W   = 35;   // headroom for a cell's trial prefix count
    localparam int CFG_W   = 2;

    // One cell per row bit, most significant bit first
    localparam int NUM_CELLS = ROW_W;

    localparam logic [ITEMS_W-1:0] MAX_ITEMS = 17'd65536;

    // Configuration register indexes
    localparam logic [CFG_W-1:0] CFG_ITEM_COUNT   = 2'd0;
    localparam logic [CFG_W-1:0] CFG_INCLUDE_SELF = 2'd1;

    // Operation codes
    localparam logic MODE_TO_CELL  = 1'b0;
    localparam logic MODE_TO_INDEX = 1'b1;

    // Item record handed from cell to cell
    typedef struct packed {
        logic               mode;
        logic [INDEX_W-1:0] flat_index;
        logic [ROW_W-1:0]   row_in;
        logic [ROW_W-1:0]   col_in;
        logic [ITEMS_W-1:0] items;       // clamped N
        logic               self_pairs;
        logic [ITEMS_W-1:0] span;        // N with self-pairs, N-1 without
        logic [INDEX_W-1:0] total;
        logic [ROW_W-1:0]   row;         // row resolved so far
        logic [INDEX_W-1:0] acc;         // pairs in rows before row
    } tpim_lane_t;

endpackage

FILE: rtl/tpim_front.sv
// ----------------------------------------------------------------------------
// tpim_front
// Configuration registers, pair total and the entry register of the chain.
// ----------------------------------------------------------------------------
module tpim_front
    import tpim_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [CFG_W-1:0]   cfg_index,
    input  logic [ITEMS_W-1:0] cfg_data,
    input  logic               accept,
    input  logic               mode,
    input  logic [INDEX_W-1:0] flat_index,
    input  logic [ROW_W-1:0]   row_in,
    input  logic [ROW_W-1:0]   col_in,
    output logic               lane_valid,
    output tpim_lane_t         lane
);

    logic [ITEMS_W-1:0]   item_count_reg;
    logic [ITEMS_W-1:0]   item_count_next;
    logic                 include_self_reg;
    logic                 include_self_next;
    logic                 lane_valid_reg;
    tpim_lane_t           lane_reg;
    tpim_lane_t           lane_next;

    logic [ITEMS_W-1:0]   items;
    logic [ITEMS_W-1:0]   factor;
    logic [2*ITEMS_W-1:0] product;

    always_comb
    begin
        item_count_next   = item_count_reg;
        include_self_next = include_self_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ITEM_COUNT:   item_count_next   = cfg_data;
                CFG_INCLUDE_SELF: include_self_next = cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_count_reg   <= '0;
            include_self_reg <= 1'b0;
        end
        else
        begin
            item_count_reg   <= item_count_next;
            include_self_reg <= include_self_next;
        end
    end

    // total = N(N+1)/2 or N(N-1)/2
    assign items   = (item_count_reg > MAX_ITEMS) ? MAX_ITEMS : item_count_reg;
    assign factor  = include_self_reg ? items + 1'b1 : items - 1'b1;
    assign product = {{ITEMS_W{1'b0}}, items} * {{ITEMS_W{1'b0}}, factor};

    always_comb
    begin
        lane_next.mode       = mode;
        lane_next.flat_index = flat_index;
        lane_next.row_in     = row_in;
        lane_next.col_in     = col_in;
        lane_next.items      = items;
        lane_next.self_pairs = include_self_reg;
        lane_next.span       = include_self_reg ? items : items - 1'b1;
        lane_next.total      = (items == '0) ? '0 : product[INDEX_W:1];
        lane_next.row        = '0;
        lane_next.acc        = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lane_valid_reg <= 1'b0;
        else
            lane_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            lane_reg <= lane_next;
    end

    assign lane_valid = lane_valid_reg;
    assign lane       = lane_reg;

endmodule

FILE: rtl/tpim_cell.sv
// ----------------------------------------------------------------------------
// tpim_cell
// One row bit of the search. Tries setting the bit and updates the prefix
// count with shifts only: rb(r+b) = rb(r) + (span-r)*b - b(b-1)/2.
// ----------------------------------------------------------------------------
module tpim_cell
    import tpim_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  tpim_lane_t lane_in,
    output logic       out_valid,
    output tpim_lane_t lane_out
);

    localparam logic [ROW_W-1:0] STEP_ROW = ROW_W'(1) << BIT;
    localparam logic [SUM_W-1:0] STEP_SUM = SUM_W'(1) << BIT;
    localparam logic [SUM_W-1:0] TRI_K    = SUM_W'((STEP_SUM >> 1) * (STEP_SUM - 1'b1));

    logic [ROW_W-1:0]   cand;
    logic [ITEMS_W-1:0] room;
    logic [SUM_W-1:0]   cand_sum;
    logic               fits;
    logic               take;
    logic               out_valid_reg;
    tpim_lane_t         lane_reg;
    tpim_lane_t         lane_next;

    assign cand     = lane_in.row | STEP_ROW;
    assign room     = lane_in.span - {1'b0, lane_in.row};
    assign cand_sum = SUM_W'(lane_in.acc) + (SUM_W'(room) << BIT) - TRI_K;
    assign fits     = ({1'b0, cand} < lane_in.span)
                   && (cand_sum <= SUM_W'(lane_in.flat_index));

    // mapping a cell to an index just follows the bits of the row
    assign take = (lane_in.mode == MODE_TO_INDEX) ? lane_in.row_in[BIT] : fits;

    always_comb
    begin
        lane_next = lane_in;
        if (take)
        begin
            lane_next.row = cand;
            lane_next.acc = cand_sum[INDEX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            lane_reg <= lane_next;
    end

    assign out_valid = out_valid_reg;
    assign lane_out  = lane_reg;

endmodule

FILE: rtl/tpim_result.sv
// ----------------------------------------------------------------------------
// tpim_result
// Final stage: range checks, column offset or pair index, result register.
// ----------------------------------------------------------------------------
module tpim_result
    import tpim_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  tpim_lane_t         lane,
    output logic               done,
    output logic [ITEMS_W-1:0] row_out,
    output logic [ITEMS_W-1:0] column_out,
    output logic [INDEX_W-1:0] index_out,
    output logic               in_range,
    output logic [INDEX_W-1:0] total_pairs
);

    logic               done_reg;
    logic [ITEMS_W-1:0] row_reg;
    logic [ITEMS_W-1:0] row_next;
    logic [ITEMS_W-1:0] column_reg;
    logic [ITEMS_W-1:0] column_next;
    logic [INDEX_W-1:0] index_reg;
    logic [INDEX_W-1:0] index_next;
    logic               in_range_reg;
    logic               in_range_next;
    logic [INDEX_W-1:0] total_reg;

    logic [INDEX_W-1:0] offset;
    logic               cell_ok;

    assign offset  = lane.flat_index - lane.acc;
    assign cell_ok = ({1'b0, lane.row_in} < lane.items)
                  && ({1'b0, lane.col_in} < lane.items)
                  && (lane.self_pairs ? (lane.col_in >= lane.row_in)
                                      : (lane.col_in >  lane.row_in));

    always_comb
    begin
        row_next      = '0;
        column_next   = '0;
        index_next    = '0;
        in_range_next = 1'b0;
        if (lane.mode == MODE_TO_CELL)
        begin
            if (lane.flat_index >= lane.total)
            begin
                row_next    = lane.items;
                column_next = lane.items;
            end
            else
            begin
                row_next      = {1'b0, lane.row};
                column_next   = {1'b0, lane.row} + offset[ITEMS_W-1:0]
                              + ITEMS_W'(!lane.self_pairs);
                in_range_next = 1'b1;
            end
        end
        else if (cell_ok)
        begin
            index_next    = lane.acc + INDEX_W'(lane.col_in - lane.row_in)
                          - INDEX_W'(!lane.self_pairs);
            in_range_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            row_reg      <= row_next;
            column_reg   <= column_next;
            index_reg    <= index_next;
            in_range_reg <= in_range_next;
            total_reg    <= lane.total;
        end
    end

    assign done        = done_reg;
    assign row_out     = row_reg;
    assign column_out  = column_reg;
    assign index_out   = index_reg;
    assign in_range    = in_range_reg;
    assign total_pairs = total_reg;

endmodule

FILE: rtl/triangular_pair_index_map.sv
// ----------------------------------------------------------------------------
// triangular_pair_index_map
// Maps a linear pair index to a cell of the upper triangle of an N x N
// matrix and back, through a chain of one-bit search cells.
// ----------------------------------------------------------------------------
//  channel   | signals                                      | handshake
//  ----------+----------------------------------------------+------------------
//  command   | mode flat_index row_in col_in                | start && !busy
//  result    | row_out column_out index_out in_range        | done strobe
//            | total_pairs                                  |
//  config    | cfg_index cfg_data                           | cfg_valid/cfg_ready
//
//  An item moves through the entry register, 16 search cells (one row bit
//  each) and the result register, which raises done for the item.
//  Every stage is registered, so a new transaction may start every cycle;
//  busy stays low and cfg_ready stays high.
//  Reset clears the configuration (N = 0, no self-pairs) and all valid bits.
//  The receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
module triangular_pair_index_map
    import tpim_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               mode,
    input  logic [INDEX_W-1:0] flat_index,
    input  logic [ROW_W-1:0]   row_in,
    input  logic [ROW_W-1:0]   col_in,
    output logic               done,
    output logic [ITEMS_W-1:0] row_out,
    output logic [ITEMS_W-1:0] column_out,
    output logic [INDEX_W-1:0] index_out,
    output logic               in_range,
    output logic [INDEX_W-1:0] total_pairs,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_W-1:0]   cfg_index,
    input  logic [ITEMS_W-1:0] cfg_data
);

    logic       accept;
    logic       chain_valid [NUM_CELLS+1];
    tpim_lane_t chain_lane  [NUM_CELLS+1];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    tpim_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .mode       (mode),
        .flat_index (flat_index),
        .row_in     (row_in),
        .col_in     (col_in),
        .lane_valid (chain_valid[0]),
        .lane       (chain_lane[0])
    );

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        tpim_cell #(
            .BIT (NUM_CELLS - 1 - g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .lane_in   (chain_lane[g]),
            .out_valid (chain_valid[g+1]),
            .lane_out  (chain_lane[g+1])
        );
    end

    tpim_result u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (chain_valid[NUM_CELLS]),
        .lane        (chain_lane[NUM_CELLS]),
        .done        (done),
        .row_out     (row_out),
        .column_out  (column_out),
        .index_out   (index_out),
        .in_range    (in_range),
        .total_pairs (total_pairs)
    );

    // a found cell never lies below the diagonal
    assert property (@(posedge clk) disable iff (!rst_n)
        done && in_range |-> column_out >= row_out)
    else $error("column below row on an in-range result");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && in_range |-> index_out < total_pairs)
    else $error("pair index not below total");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && !in_range |-> index_out == '0 && row_out == column_out)
    else $error("out-of-range result fields inconsistent");

    // done is set by the result register, after the entry register and the cells
    assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(NUM_CELLS + 2) done)
    else $error("result strobe missing after start");

endmodule
